// ===== sv/bpe_pkg.sv =====
// package for the bezier patch evaluator: sizes, coordinate types, blend function
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bpe_pkg;
  localparam int GridSide = 4;
  localparam int IdxW = 2;
  localparam int CoordW = 32;
  localparam int ParamW = 17;
  localparam logic [ParamW-1:0] OneQ16 = 17'h10000;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic                  op;
    logic [IdxW-1:0]       row_index;
    logic [IdxW-1:0]       col_index;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [ParamW-1:0]     u_param;
    logic [ParamW-1:0]     v_param;
  } in_item_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROW  = 4'b0010,
    ST_COL  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  localparam logic OpLoad = 1'b0;
  localparam logic OpEval = 1'b1;

  // t*a + (1-t)*b with each product floored to q16, sum wraps
  function automatic coord_t blend(coord_t a, coord_t b, logic [ParamW-1:0] t);
    logic signed [49:0] pa;
    logic signed [49:0] pb;
    logic signed [17:0] ts;
    logic signed [17:0] tn;
    ts = $signed({1'b0, t});
    tn = $signed({1'b0, OneQ16 - t});
    pa = 50'(a * ts);
    pb = 50'(b * tn);
    return coord_t'(pa[47:16] + pb[47:16]);
  endfunction
endpackage
`default_nettype wire

// ===== sv/bpe_if.sv =====
// valid/ready channel carrying one item
// depends on nothing, payload type is a parameter of the channel
`timescale 1ns / 1ps
`default_nettype none
interface bpe_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/bpe_cell.sv =====
// one cell of the de casteljau chain: holds one point, blends with right neighbor
// depends on bpe_pkg
`timescale 1ns / 1ps
`default_nettype none
module bpe_cell (
  input  wire logic                         clk_i,
  input  wire logic                         load_i,
  input  wire bpe_pkg::point_t              load_pt_i,
  input  wire logic                         step_i,
  input  wire bpe_pkg::point_t              right_i,
  input  wire logic [bpe_pkg::ParamW-1:0]   t_i,
  output bpe_pkg::point_t                   pt_o
);
  import bpe_pkg::*;
  point_t pt_q, pt_d;

  always_comb begin
    pt_d = pt_q;
    if (load_i) begin
      pt_d = load_pt_i;
    end else if (step_i) begin
      pt_d.x = blend(pt_q.x, right_i.x, t_i);
      pt_d.y = blend(pt_q.y, right_i.y, t_i);
      pt_d.z = blend(pt_q.z, right_i.z, t_i);
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
  end
  assign pt_o = pt_q;
endmodule
`default_nettype wire

// ===== sv/bezier_patch_evaluator_core.sv =====
// channel  dir  payload
// in_ch    in   op, row_index, col_index, coord_x/y/z, u_param, v_param
// out_ch   out  point_x/y/z
// a load writes the grid and leaves the block idle; an evaluate takes 4 row passes
// (copy, 3 blend steps, store) plus one column pass, then the output register;
// the chain of 4 cells does one blend level per cycle, and the result is held
// until taken, after which the block returns to idle.
// reset clears control only; grid registers hold garbage until loaded.
// no new item is taken until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module bezier_patch_evaluator_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bpe_if.sink       in_ch,
  bpe_if.source     out_ch
);
  import bpe_pkg::*;

  point_t grid_q [GridSide*GridSide];
  point_t rowres_q [GridSide];
  point_t cell_pt [GridSide];
  point_t cell_in [GridSide];
  point_t load_pt [GridSide];
  state_e state_q, state_d;
  logic [IdxW-1:0] row_q, row_d;
  logic [IdxW:0] step_q, step_d;
  logic [ParamW-1:0] u_q, v_q;
  point_t out_q;
  logic cell_load, cell_step;
  logic accept;
  in_item_t din;

  assign din = in_ch.data;
  assign in_ch.ready = (state_q == ST_IDLE);
  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i) begin
    if (accept && din.op == OpLoad) begin
      grid_q[{din.row_index, din.col_index}] <= '{x: din.coord_x, y: din.coord_y,
                                                z: din.coord_z};
    end
    if (accept && din.op == OpEval) begin
      u_q <= (din.u_param > OneQ16) ? OneQ16 : din.u_param;
      v_q <= (din.v_param > OneQ16) ? OneQ16 : din.v_param;
    end
    if (state_q == ST_ROW && step_q == 3'(GridSide)) begin
      rowres_q[row_q] <= cell_pt[0];
    end
    if (state_q == ST_COL && step_q == 3'(GridSide)) begin
      out_q <= cell_pt[0];
    end
  end

  // step 0 loads the chain, steps 1..3 blend, step 4 stores cell 0
  assign cell_load = (state_q == ST_ROW || state_q == ST_COL) && step_q == '0;
  assign cell_step = (state_q == ST_ROW || state_q == ST_COL) && step_q != '0
                     && step_q != 3'(GridSide);

  for (genvar i = 0; i < GridSide; i++) begin : g_cell
    assign load_pt[i] = (state_q == ST_COL) ? rowres_q[i]
                                            : grid_q[{row_q, IdxW'(i)}];
    if (i == GridSide - 1) begin : g_last
      assign cell_in[i] = cell_pt[i];
    end else begin : g_mid
      assign cell_in[i] = cell_pt[i+1];
    end
    bpe_cell u_cell (
      .clk_i     (clk_i),
      .load_i    (cell_load),
      .load_pt_i (load_pt[i]),
      .step_i    (cell_step),
      .right_i   (cell_in[i]),
      .t_i       ((state_q == ST_COL) ? v_q : u_q),
      .pt_o      (cell_pt[i])
    );
  end

  always_comb begin
    state_d = state_q;
    row_d = row_q;
    step_d = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && din.op == OpEval) begin
          state_d = ST_ROW;
          row_d = '0;
          step_d = '0;
        end
      end
      ST_ROW: begin
        if (step_q == 3'(GridSide)) begin
          step_d = '0;
          if (row_q == IdxW'(GridSide - 1)) begin
            state_d = ST_COL;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_COL: begin
        if (step_q == 3'(GridSide)) begin
          state_d = ST_OUT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q <= '0;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      row_q <= row_d;
      step_q <= step_d;
    end
  end

  assign out_ch.valid = (state_q == ST_OUT);
  assign out_ch.data = out_q;

  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= 3'(GridSide)) else $error("step counter out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped");
endmodule
`default_nettype wire

// ===== sim/bezier_patch_evaluator_core_test.sv =====
// testbench for bezier_patch_evaluator_core: loads control grids, evaluates patch points
// depends on bpe_pkg, bpe_if and bezier_patch_evaluator_core; checks every point against a de casteljau predictor
`timescale 1ns / 1ps
`default_nettype none
module bezier_patch_evaluator_core_test;
  import bpe_pkg::*;

  typedef struct {
    in_item_t item;
    bit       has_known;
    point_t   known;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  bpe_if #(.T(in_item_t)) in_ch ();
  bpe_if #(.T(point_t))   out_ch ();

  bezier_patch_evaluator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  coord_t   grid_x_q[GridSide*GridSide];
  coord_t   grid_y_q[GridSide*GridSide];
  coord_t   grid_z_q[GridSide*GridSide];
  point_t   pending_points[$];
  int       mismatches = 0;
  int       points_seen = 0;
  int       items_sent = 0;
  int       evals_sent = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  longint   cycle_count = 0;
  stim_row_t directed[$];
  bit       table_has_known = 1'b0;
  point_t   table_known = '0;

  // floor(t*a/65536) + floor((1-t)*b/65536), wrapped to 32 bits
  function automatic coord_t lerp_q16(coord_t a, coord_t b, longint t);
    longint pa;
    longint pb;
    pa = (longint'(a) * t) >>> 16;
    pb = (longint'(b) * (65536 - t)) >>> 16;
    return coord_t'(pa + pb);
  endfunction

  function automatic point_t eval_patch(logic [ParamW-1:0] u_raw, logic [ParamW-1:0] v_raw);
    longint u;
    longint v;
    coord_t rx[GridSide];
    coord_t ry[GridSide];
    coord_t rz[GridSide];
    coord_t cx[GridSide];
    coord_t cy[GridSide];
    coord_t cz[GridSide];
    point_t p;
    u = (u_raw > OneQ16) ? 65536 : longint'(u_raw);
    v = (v_raw > OneQ16) ? 65536 : longint'(v_raw);
    for (int r = 0; r < GridSide; r++) begin
      for (int c = 0; c < GridSide; c++) begin
        rx[c] = grid_x_q[r*GridSide+c];
        ry[c] = grid_y_q[r*GridSide+c];
        rz[c] = grid_z_q[r*GridSide+c];
      end
      for (int n = GridSide; n > 1; n--)
        for (int i = 0; i < n-1; i++) begin
          rx[i] = lerp_q16(rx[i], rx[i+1], u);
          ry[i] = lerp_q16(ry[i], ry[i+1], u);
          rz[i] = lerp_q16(rz[i], rz[i+1], u);
        end
      cx[r] = rx[0];
      cy[r] = ry[0];
      cz[r] = rz[0];
    end
    for (int n = GridSide; n > 1; n--)
      for (int i = 0; i < n-1; i++) begin
        cx[i] = lerp_q16(cx[i], cx[i+1], v);
        cy[i] = lerp_q16(cy[i], cy[i+1], v);
        cz[i] = lerp_q16(cz[i], cz[i+1], v);
      end
    p.x = cx[0];
    p.y = cy[0];
    p.z = cz[0];
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  function automatic in_item_t make_load(int r, int c, coord_t x, coord_t y, coord_t z);
    in_item_t it;
    it.op = OpLoad;
    it.row_index = IdxW'(r);
    it.col_index = IdxW'(c);
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.u_param = ParamW'($urandom);
    it.v_param = ParamW'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_eval(logic [ParamW-1:0] u, logic [ParamW-1:0] v);
    in_item_t it;
    it.op = OpEval;
    it.row_index = IdxW'($urandom);
    it.col_index = IdxW'($urandom);
    it.coord_x = coord_t'($urandom);
    it.coord_y = coord_t'($urandom);
    it.coord_z = coord_t'($urandom);
    it.u_param = u;
    it.v_param = v;
    return it;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return coord_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [ParamW-1:0] rand_param();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return OneQ16;
      2: return ParamW'($urandom_range(65537, 131071));
      default: return ParamW'($urandom_range(0, 65536));
    endcase
  endfunction

  // predictor and queue update at the accepting edge
  always @(posedge clk_i) begin
    point_t want_pt;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.data.op == OpLoad) begin
          grid_x_q[in_ch.data.row_index*GridSide+in_ch.data.col_index] = in_ch.data.coord_x;
          grid_y_q[in_ch.data.row_index*GridSide+in_ch.data.col_index] = in_ch.data.coord_y;
          grid_z_q[in_ch.data.row_index*GridSide+in_ch.data.col_index] = in_ch.data.coord_z;
        end else begin
          want_pt = eval_patch(in_ch.data.u_param, in_ch.data.v_param);
          // typed-in table rows pin the predictor itself
          if (table_has_known && want_pt !== table_known)
            report_mismatch("table row", want_pt.x, table_known.x);
          pending_points.insert(pending_points.size(), want_pt);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        points_seen++;
        if (pending_points.size() == 0) begin
          report_mismatch("unexpected point", out_ch.data.x, '0);
        end else begin
          point_t want;
          want = pending_points.pop_front();
          if (out_ch.data.x !== want.x) report_mismatch("point_x", out_ch.data.x, want.x);
          if (out_ch.data.y !== want.y) report_mismatch("point_y", out_ch.data.y, want.y);
          if (out_ch.data.z !== want.z) report_mismatch("point_z", out_ch.data.z, want.z);
        end
      end
      if (cycle_count > 2000000) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // valid stays up between items unless the sender idles
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    if (it.op == OpEval) evals_sent++;
  endtask

  task automatic load_full_grid();
    for (int r = 0; r < GridSide; r++)
      for (int c = 0; c < GridSide; c++)
        send_item(make_load(r, c, rand_coord(), rand_coord(), rand_coord()));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    stim_row_t row;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: constant grid gives that constant at u = v = 0 and at u = v = 1
    for (int k = 0; k < GridSide*GridSide; k++) begin
      row.item = make_load(k / GridSide, k % GridSide, 32'sh00010000, 32'sh80000000,
                           32'sh7fffffff);
      row.has_known = 1'b0;
      directed.insert(directed.size(), row);
    end
    row.item = make_eval('0, '0);
    row.has_known = 1'b1;
    row.known = '{32'sh00010000, 32'sh80000000, 32'sh7fffffff};
    directed.insert(directed.size(), row);
    row.item = make_eval(OneQ16, OneQ16);
    directed.insert(directed.size(), row);
    // load with x = -1 at row 0 col 0 only; u=v=1 picks the first point
    row.item = make_load(0, 0, 32'shffffffff, 32'sh00000000, 32'sh12345678);
    row.has_known = 1'b0;
    directed.insert(directed.size(), row);
    row.item = make_eval(OneQ16, OneQ16);
    row.has_known = 1'b1;
    row.known = '{32'shffffffff, 32'sh00000000, 32'sh12345678};
    directed.insert(directed.size(), row);
    // parameter above one saturates
    row.item = make_eval(17'h1ffff, 17'h10001);
    directed.insert(directed.size(), row);
    row.item = make_eval(17'h08000, 17'h00001);
    row.has_known = 1'b0;
    directed.insert(directed.size(), row);
    row.item = make_eval(17'h0ffff, 17'h0c000);
    directed.insert(directed.size(), row);

    foreach (directed[k]) begin
      table_has_known <= directed[k].has_known;
      table_known <= directed[k].known;
      send_item(directed[k].item);
    end
    wait_drained();
    table_has_known <= 1'b0;

    // random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 49 : (ph == 3) ? 18 : 0;
      recv_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 18 : 0;
      for (int n = 0; n < 400; ) begin
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          load_full_grid();
          n += GridSide*GridSide;
        end else if (pick < 5) begin
          send_item(make_load($urandom_range(0, 3), $urandom_range(0, 3),
                              rand_coord(), rand_coord(), rand_coord()));
          n++;
        end else begin
          send_item(make_eval(rand_param(), rand_param()));
          n++;
        end
        if (n % 97 == 0) wait_drained();
      end
      wait_drained();
    end
    repeat (40) @(posedge clk_i);
    $display("sent %0d items, %0d evaluations, checked %0d points", items_sent, evals_sent,
             points_seen);
    $display("covered constant grids, parameter extremes and saturation, four idle phases");
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
